FILE: rtl/scc_pkg.sv
// Shared types and constants of the sector cache tag and replacement controller.
package scc_pkg;

  localparam int unsigned EntriesDef = 64;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned SectorW    = 32;
  localparam int unsigned SlotW      = 6;

  typedef enum logic [ModeW-1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [SectorW-1:0] sector;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic               hit;
    logic               fetch_needed;
    logic               writeback_needed;
    logic [SectorW-1:0] writeback_sector;
    logic               last;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HIT,
    ST_SWEEP,
    ST_VREAD,
    ST_VWRITE,
    ST_FL_SCAN,
    ST_FL_CAP,
    ST_FL_END
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic lookup;
    logic pick_free;
    logic sweep;
    logic vread;
    logic vwrite;
    logic hit_upd;
    logic fl_scan;
    logic fl_cap;
    logic fl_end;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;
    logic lookup_done;
    logic free_found;
    logic sweep_found;
    logic fl_done;
    logic fl_dirty;
    logic have_pend;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/scc_if.sv
// Request and result channel interfaces with valid/ready handshake.
interface scc_req_if;
  import scc_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface scc_rsp_if;
  import scc_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/sector_cache_clock_replacement.sv
// Top level of the fully associative sector cache tag and clock replacement controller.
//
//  channel | dir | payload                                             | transfer when
//  --------+-----+-----------------------------------------------------+---------------
//  req_i   | in  | mode, sector                                        | valid & ready
//  rsp_o   | out | slot, hit, fetch_needed, writeback_needed,          | valid & ready
//          |     | writeback_sector, last                              |
//
//  One request at a time. The tag memory has one port and is scanned one slot per cycle;
//  a flush scan stops at each dirty slot to capture it, waiting there while the held
//  writeback cannot yet be emitted. A miss with all slots valid steps the clock hand to a
//  slot with a clear reference bit; the victim slot is then read and updated.
//  Reset clears valid, dirty and reference bits and the clock hand at once; no clearing pass.
//  A full result register decouples the sides: a stalled result holds the sequencer only
//  when the next result is ready to go.
module sector_cache_clock_replacement #(
  parameter int unsigned ENTRIES = scc_pkg::EntriesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scc_req_if.sink   req_i,
  scc_rsp_if.source rsp_o
);
  import scc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: walks lookup, clock sweep, victim update and flush scan.
  scc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_mode_i  (req_i.payload.mode),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: tag memory, status bits, clock hand and the result register.
  scc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i.payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_o.payload)
  );

endmodule

FILE: rtl/scc_ctrl.sv
// Sequencing state machine of the sector cache controller.
module scc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  logic [scc_pkg::ModeW-1:0]      req_mode_i,
  output logic                           req_ready_o,
  input  scc_pkg::sts_t                  sts_i,
  output scc_pkg::cmd_t                  cmd_o
);
  import scc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          if (req_mode_i inside {MODE_READ, MODE_WRITE}) begin
            state_d = ST_LOOKUP;
          end else if (req_mode_i == MODE_FLUSH) begin
            state_d = ST_FL_SCAN;
          end
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (sts_i.match) begin
          state_d = ST_HIT;
        end else if (sts_i.lookup_done) begin
          if (sts_i.free_found) begin
            cmd_o.pick_free = 1'b1;
            state_d         = ST_VREAD;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.hit_upd = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_found) begin
          state_d = ST_VREAD;
        end
      end
      ST_VREAD: begin
        cmd_o.vread = 1'b1;
        state_d     = ST_VWRITE;
      end
      ST_VWRITE: begin
        if (sts_i.out_free) begin
          cmd_o.vwrite = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_FL_SCAN: begin
        cmd_o.fl_scan = 1'b1;
        if (sts_i.fl_done) begin
          state_d = ST_FL_END;
        end else if (sts_i.fl_dirty) begin
          state_d = ST_FL_CAP;
        end
      end
      ST_FL_CAP: begin
        // emit the held writeback before taking the new one
        if (!sts_i.have_pend || sts_i.out_free) begin
          cmd_o.fl_cap = 1'b1;
          state_d      = ST_FL_SCAN;
        end
      end
      ST_FL_END: begin
        if (sts_i.out_free) begin
          cmd_o.fl_end = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/scc_dpath.sv
// Tag memory, slot status bits, clock hand, scan counters and result register.
module scc_dpath #(
  parameter int unsigned ENTRIES = scc_pkg::EntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scc_pkg::req_t req_i,
  input  scc_pkg::cmd_t cmd_i,
  output scc_pkg::sts_t sts_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output scc_pkg::rsp_t rsp_o
);
  import scc_pkg::*;

  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(ENTRIES + 1);
  localparam int unsigned RCW = $clog2(MaxResults + 1);
  localparam int unsigned XW  = IW + SlotW;

  // request held for the whole access
  logic [SectorW-1:0] sector_q;
  logic               write_q;

  // scan state
  logic [CW-1:0]  cnt_q;
  logic [RCW-1:0] count_q;
  logic           free_found_q;
  logic [IW-1:0]  free_slot_q;
  logic [IW-1:0]  hit_slot_q;
  logic [IW-1:0]  victim_q;
  logic [IW-1:0]  hand_q;

  // per-slot status
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] dirty_q;
  logic [ENTRIES-1:0] ref_q;

  // tag memory, one read or write port per cycle
  logic [SectorW-1:0] tag_mem [ENTRIES];
  logic [SectorW-1:0] rdata_q;
  logic               rd_vld_q;
  logic [IW-1:0]      rd_idx_q;

  // held flush writeback
  logic               have_pend_q;
  logic [IW-1:0]      pend_slot_q;
  logic [SectorW-1:0] pend_tag_q;

  logic               out_valid_q;
  rsp_t               out_q;

  logic [IW-1:0] scan_idx;
  logic [IW-1:0] hand_nxt;
  logic [IW-1:0] mem_raddr;
  logic [IW-1:0] out_idx;
  logic [XW-1:0] out_ext;
  logic          scan_end;
  logic          rd_go;
  logic          fl_go;
  logic          fl_take;
  logic          mem_re;
  logic          match;
  logic          fl_done;
  logic          out_free;
  logic          out_load;
  logic          victim_wb;
  rsp_t          out_d;

  assign scan_idx = cnt_q[IW-1:0];
  assign scan_end = (cnt_q == CW'(ENTRIES));
  assign hand_nxt = (hand_q == IW'(ENTRIES - 1)) ? '0 : hand_q + IW'(1);
  assign match    = rd_vld_q && valid_q[rd_idx_q] && (rdata_q == sector_q);
  assign fl_done  = scan_end || (count_q == RCW'(MaxResults));
  assign rd_go    = cmd_i.lookup && !scan_end;
  assign fl_go    = cmd_i.fl_scan && !fl_done;
  assign fl_take  = fl_go && valid_q[scan_idx] && dirty_q[scan_idx];
  assign mem_re   = rd_go || fl_take || cmd_i.vread;
  assign mem_raddr = cmd_i.vread ? victim_q : scan_idx;
  assign out_free = !out_valid_q || rsp_ready_i;
  assign victim_wb = valid_q[victim_q] && dirty_q[victim_q];

  always_comb begin
    sts_o             = '0;
    sts_o.match       = match;
    sts_o.lookup_done = scan_end && !rd_vld_q;
    sts_o.free_found  = free_found_q;
    sts_o.sweep_found = !ref_q[hand_nxt];
    sts_o.fl_done     = fl_done;
    sts_o.fl_dirty    = valid_q[scan_idx] && dirty_q[scan_idx];
    sts_o.have_pend   = have_pend_q;
    sts_o.out_free    = out_free;
  end

  // result assembly; slot numbers beyond the field width are masked
  assign out_idx = cmd_i.hit_upd ? hit_slot_q : (cmd_i.vwrite ? victim_q : pend_slot_q);
  assign out_ext = XW'(out_idx);
  assign out_load = cmd_i.hit_upd || cmd_i.vwrite || cmd_i.fl_end ||
                    (cmd_i.fl_cap && have_pend_q);

  always_comb begin
    out_d      = '0;
    out_d.slot = out_ext[SlotW-1:0];
    if (cmd_i.hit_upd) begin
      out_d.hit  = 1'b1;
      out_d.last = 1'b1;
    end else if (cmd_i.vwrite) begin
      out_d.fetch_needed     = 1'b1;
      out_d.writeback_needed = victim_wb;
      out_d.writeback_sector = victim_wb ? rdata_q : '0;
      out_d.last             = 1'b1;
    end else if (have_pend_q) begin
      out_d.writeback_needed = 1'b1;
      out_d.writeback_sector = pend_tag_q;
      out_d.last             = cmd_i.fl_end;
    end else begin
      // flush with nothing dirty
      out_d.slot = '0;
      out_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vwrite) begin
      tag_mem[victim_q] <= sector_q;
    end
    if (mem_re) begin
      rdata_q <= tag_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sector_q <= req_i.sector;
      write_q  <= (req_i.mode == MODE_WRITE);
    end
    if (mem_re) begin
      rd_idx_q <= mem_raddr;
    end
    if (rd_go && !free_found_q && !valid_q[scan_idx]) begin
      free_slot_q <= scan_idx;
    end
    if (cmd_i.lookup && match) begin
      hit_slot_q <= rd_idx_q;
    end
    if (cmd_i.pick_free) begin
      victim_q <= free_slot_q;
    end else if (cmd_i.sweep) begin
      victim_q <= hand_nxt;
    end
    if (cmd_i.fl_cap) begin
      pend_slot_q <= rd_idx_q;
      pend_tag_q  <= rdata_q;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      count_q      <= '0;
      free_found_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      have_pend_q  <= 1'b0;
      hand_q       <= '0;
      valid_q      <= '0;
      dirty_q      <= '0;
      ref_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_vld_q <= rd_go;
      if (cmd_i.accept) begin
        cnt_q        <= '0;
        count_q      <= '0;
        free_found_q <= 1'b0;
        have_pend_q  <= 1'b0;
      end else if (rd_go || fl_go) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (rd_go && !valid_q[scan_idx]) begin
        free_found_q <= 1'b1;
      end
      if (fl_take) begin
        count_q           <= count_q + RCW'(1);
        dirty_q[scan_idx] <= 1'b0;
      end
      if (cmd_i.fl_cap) begin
        have_pend_q <= 1'b1;
      end
      if (cmd_i.sweep) begin
        hand_q <= hand_nxt;
        if (ref_q[hand_nxt]) begin
          ref_q[hand_nxt] <= 1'b0;
        end
      end
      if (cmd_i.hit_upd) begin
        ref_q[hit_slot_q] <= 1'b1;
        if (write_q) begin
          dirty_q[hit_slot_q] <= 1'b1;
        end
      end
      if (cmd_i.vwrite) begin
        valid_q[victim_q] <= 1'b1;
        dirty_q[victim_q] <= write_q;
        ref_q[victim_q]   <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

FILE: rtl/scc_chk.sv
// Port-level assertions for the sector cache controller and their bind.
module scc_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input scc_pkg::req_t req_payload_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input scc_pkg::rsp_t rsp_payload_i
);
  import scc_pkg::*;

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("result changed while stalled");

  // drop ready after taking a real request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i &&
    (req_payload_i.mode == MODE_READ || req_payload_i.mode == MODE_WRITE ||
     req_payload_i.mode == MODE_FLUSH) |=> !req_ready_i)
    else $error("request taken while busy");

  a_unused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_payload_i.mode == MODE_NONE |=> req_ready_i)
    else $error("unused mode left the idle state");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.hit |->
    !rsp_payload_i.fetch_needed && !rsp_payload_i.writeback_needed && rsp_payload_i.last)
    else $error("hit result carries miss fields");

  a_wb_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.writeback_needed |-> rsp_payload_i.writeback_sector == '0)
    else $error("writeback sector without writeback");

endmodule

bind sector_cache_clock_replacement scc_chk u_scc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_payload_i (req_i.payload),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);
